// ----- design/x86_integer_subset_executor_assert.svh -----
// Assertion macros for the x86 subset executor.
// Needs clk_i and rst_ni in the scope of the user.
`ifndef X86_INTEGER_SUBSET_EXECUTOR_ASSERT_SVH
`define X86_INTEGER_SUBSET_EXECUTOR_ASSERT_SVH
`define X86ISE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define X86ISE_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);
`endif

// ----- design/x86ise_pkg.sv -----
// Shared types and codes of the x86 subset executor.
// No dependencies.
package x86ise_pkg;
  typedef enum logic [1:0] {
    CMD_EXEC = 2'd0,
    CMD_LOAD = 2'd1,
    CMD_READ = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BAD_RM = 2'd1,
    ST_BAD_OP = 2'd2
  } status_e;

  localparam logic [3:0] RI_EIP   = 4'd8;
  localparam logic [3:0] RI_FLAGS = 4'd9;

  localparam logic [31:0] FLAG_CF = 32'h1;
  localparam logic [31:0] FLAG_PF = 32'h4;
  localparam logic [31:0] FLAG_ZF = 32'h40;
  localparam logic [31:0] FLAG_SF = 32'h80;
  localparam logic [31:0] FLAG_OF = 32'h800;

  typedef logic [7:0][31:0] regfile_t;

  typedef struct packed {
    status_e     status;
    logic [2:0]  instr_len;
    logic [31:0] next_ip;
    logic        mem_write_valid;
    logic [31:0] mem_write_addr;
    logic [31:0] mem_write_data;
    logic [31:0] read_value;
  } result_t;
endpackage

// ----- design/x86ise_exec.sv -----
// Combinational execute step: state and one word in, next state and result out.
// Depends on x86ise_pkg.
module x86ise_exec import x86ise_pkg::*; (
  input  cmd_e        command_i,
  input  logic [7:0]  opcode_i,
  input  logic [7:0]  byte_one_i,
  input  logic [7:0]  byte_two_i,
  input  logic [7:0]  byte_three_i,
  input  logic [7:0]  byte_four_i,
  input  logic [7:0]  byte_five_i,
  input  logic [3:0]  reg_index_i,
  input  logic [31:0] reg_value_i,
  input  regfile_t    regs_i,
  input  logic [31:0] ip_i,
  input  logic [31:0] flags_i,
  output regfile_t    regs_o,
  output logic [31:0] ip_o,
  output logic [31:0] flags_o,
  output result_t     res_o
);
  logic [1:0]  md;
  logic [2:0]  rf, rr;
  logic [31:0] imm, imm2, s8, s8b, a, b, cf, val, t, sv;
  logic [4:0]  cnt;
  logic        ok, xfer, taken, zf, sf, of, cff, pf, cond, setf;
  logic [31:0] target;
  regfile_t    g;
  logic [2:0]  n;
  status_e     st;

  assign md   = byte_one_i[7:6];
  assign rf   = byte_one_i[5:3];
  assign rr   = byte_one_i[2:0];
  assign imm  = {byte_four_i, byte_three_i, byte_two_i, byte_one_i};
  assign imm2 = {byte_five_i, byte_four_i, byte_three_i, byte_two_i};
  assign s8   = {{24{byte_one_i[7]}}, byte_one_i};
  assign s8b  = {{24{byte_two_i[7]}}, byte_two_i};
  assign a    = regs_i[rr];
  assign b    = regs_i[rf];
  assign cf   = {31'd0, flags_i[0]};
  assign zf   = (flags_i & FLAG_ZF) != '0;
  assign sf   = (flags_i & FLAG_SF) != '0;
  assign of   = (flags_i & FLAG_OF) != '0;
  assign cff  = (flags_i & FLAG_CF) != '0;
  assign pf   = (flags_i & FLAG_PF) != '0;

  always_comb begin
    unique case (opcode_i[3:1])
      3'd0: cond = of;
      3'd1: cond = cff;
      3'd2: cond = zf;
      3'd3: cond = cff | zf;
      3'd4: cond = sf;
      3'd5: cond = pf;
      3'd6: cond = sf ^ of;
      default: cond = zf | (sf ^ of);
    endcase
    taken = cond ^ opcode_i[0];
  end

  always_comb begin
    cnt = (opcode_i == 8'hC1) ? byte_two_i[4:0] : regs_i[1][4:0];
    unique case (rf)
      3'd4: sv = a << cnt;
      3'd5: sv = a >> cnt;
      3'd7: sv = $unsigned($signed(a) >>> cnt);
      default: sv = a;
    endcase
  end

  always_comb begin
    g      = regs_i;
    st     = ST_OK;
    n      = 3'd0;
    xfer   = 1'b0;
    target = '0;
    setf   = 1'b0;
    val    = '0;
    res_o  = '0;
    unique case (opcode_i)
      8'h89, 8'h8B, 8'h87, 8'hC7, 8'h01, 8'h29, 8'h31, 8'h21, 8'h09,
      8'h03, 8'h2B, 8'h33, 8'h23, 8'h0B, 8'h39, 8'h3B, 8'h85, 8'h13, 8'h1B: begin
        if (md != 2'd3) begin
          st = ST_BAD_RM;
        end else begin
          n = 3'd2;
          unique case (opcode_i)
            8'h89: g[rr] = b;
            8'h8B: g[rf] = a;
            8'h87: begin
              g[rf] = a;
              g[rr] = b;
            end
            8'hC7: begin
              g[rr] = imm2;
              n = 3'd6;
            end
            8'h01: begin val = a + b; g[rr] = val; setf = 1'b1; end
            8'h29: begin val = a - b; g[rr] = val; setf = 1'b1; end
            8'h31: begin val = a ^ b; g[rr] = val; setf = 1'b1; end
            8'h21: begin val = a & b; g[rr] = val; setf = 1'b1; end
            8'h09: begin val = a | b; g[rr] = val; setf = 1'b1; end
            8'h03: g[rf] = b + a;
            8'h2B: g[rf] = b - a;
            8'h33: g[rf] = b ^ a;
            8'h23: g[rf] = b & a;
            8'h0B: g[rf] = b | a;
            8'h39: begin val = a - b; setf = 1'b1; end
            8'h3B: begin val = b - a; setf = 1'b1; end
            8'h85: begin val = a & b; setf = 1'b1; end
            8'h13: g[rf] = b + a + cf;
            default: g[rf] = b - a - cf;
          endcase
        end
      end
      8'h8D: begin
        if (md == 2'd1) begin
          g[rf] = a + s8b;
          n = 3'd3;
        end else if (md == 2'd2) begin
          g[rf] = a + imm2;
          n = 3'd6;
        end else begin
          st = ST_BAD_RM;
        end
      end
      8'h05: begin g[0] = regs_i[0] + imm; n = 3'd5; end
      8'h2D: begin g[0] = regs_i[0] - imm; n = 3'd5; end
      8'h35: begin g[0] = regs_i[0] ^ imm; n = 3'd5; end
      8'h25: begin g[0] = regs_i[0] & imm; n = 3'd5; end
      8'h0D: begin g[0] = regs_i[0] | imm; n = 3'd5; end
      8'h3D: begin val = regs_i[0] - imm; setf = 1'b1; n = 3'd5; end
      8'hA9: begin val = regs_i[0] & imm; setf = 1'b1; n = 3'd5; end
      8'h15: begin g[0] = regs_i[0] + imm + cf; n = 3'd5; end
      8'h1D: begin g[0] = regs_i[0] - imm - cf; n = 3'd5; end
      8'hC1: begin g[rr] = sv; n = 3'd3; end
      8'hD3: begin g[rr] = sv; n = 3'd2; end
      8'h98: begin
        g[0] = {{16{regs_i[0][15]}}, regs_i[0][15:0]};
        n = 3'd1;
      end
      8'h99: begin g[2] = {32{regs_i[0][31]}}; n = 3'd1; end
      8'h90: n = 3'd1;
      8'hCD: n = 3'd2;
      8'hE8: begin
        g[4] = regs_i[4] - 32'd4;
        res_o.mem_write_valid = 1'b1;
        res_o.mem_write_addr  = g[4];
        res_o.mem_write_data  = ip_i + 32'd5;
        xfer   = 1'b1;
        target = ip_i + 32'd5 + imm;
      end
      8'hE9: begin xfer = 1'b1; target = ip_i + 32'd5 + imm; end
      8'hEB: begin xfer = 1'b1; target = ip_i + 32'd2 + s8; end
      default: begin
        if (opcode_i[7:4] == 4'h7) begin
          if (taken) begin
            xfer   = 1'b1;
            target = ip_i + 32'd2 + s8;
          end else begin
            n = 3'd2;
          end
        end else begin
          st = ST_BAD_OP;
          n  = 3'd1;
        end
      end
    endcase

    regs_o  = regs_i;
    ip_o    = ip_i;
    flags_o = flags_i;
    t       = '0;
    ok      = (st == ST_OK);
    unique case (command_i)
      CMD_LOAD: begin
        res_o = '0;
        if (!reg_index_i[3]) regs_o[reg_index_i[2:0]] = reg_value_i;
        else if (reg_index_i == RI_EIP) ip_o = reg_value_i;
        else if (reg_index_i == RI_FLAGS) flags_o = reg_value_i;
      end
      CMD_READ: begin
        res_o = '0;
        if (!reg_index_i[3]) t = regs_i[reg_index_i[2:0]];
        else if (reg_index_i == RI_EIP) t = ip_i;
        else if (reg_index_i == RI_FLAGS) t = flags_i;
        res_o.read_value = t;
      end
      CMD_EXEC: begin
        res_o.status = st;
        if (ok) begin
          regs_o = g;
          if (setf) begin
            flags_o = (flags_i & ~(FLAG_ZF | FLAG_SF | FLAG_CF))
                    | ((val == '0) ? FLAG_ZF : '0)
                    | (val[31] ? FLAG_SF : '0);
          end
          if (xfer) begin
            ip_o = target;
            n    = 3'd0;
          end else begin
            ip_o = ip_i + {29'd0, n};
          end
        end else if (st == ST_BAD_RM) begin
          n = 3'd0;
        end
        res_o.instr_len = n;
      end
      default: res_o = '0;
    endcase
    res_o.next_ip = ip_o;
  end
endmodule

// ----- design/x86_integer_subset_executor.sv -----
// x86 integer subset executor: result word appears the cycle after the word is accepted.
// 1 word per cycle unless a result stalls; the execute step feeds the result register.
// The result register decouples the sides: a new word is taken while a result is taken.
// Reset clears registers, eip, flags and the result valid.
// Depends on x86ise_pkg, x86ise_exec and the assertion header.
`include "x86_integer_subset_executor_assert.svh"
module x86_integer_subset_executor import x86ise_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // opcode, byte_one..byte_five, reg_index[51:48], reg_value[83:52], zero pad
  input  logic [87:0]  s_axis_tdata_i,
  // command
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // status, instr_len, next_ip, mem_write_valid, mem_write_addr,
  // mem_write_data, read_value, zero pad
  output logic [135:0] m_axis_tdata_o
);
  regfile_t    regs_q, regs_d;
  logic [31:0] ip_q, ip_d, flags_q, flags_d;
  result_t     res_q, res_d;
  logic        vld_q, acc;

  assign s_axis_tready_o = !vld_q || m_axis_tready_i;
  assign acc = s_axis_tvalid_i && s_axis_tready_o;

  x86ise_exec u_exec (
    .command_i    (cmd_e'(s_axis_tuser_i)),
    .opcode_i     (s_axis_tdata_i[7:0]),
    .byte_one_i   (s_axis_tdata_i[15:8]),
    .byte_two_i   (s_axis_tdata_i[23:16]),
    .byte_three_i (s_axis_tdata_i[31:24]),
    .byte_four_i  (s_axis_tdata_i[39:32]),
    .byte_five_i  (s_axis_tdata_i[47:40]),
    .reg_index_i  (s_axis_tdata_i[51:48]),
    .reg_value_i  (s_axis_tdata_i[83:52]),
    .regs_i       (regs_q),
    .ip_i         (ip_q),
    .flags_i      (flags_q),
    .regs_o       (regs_d),
    .ip_o         (ip_d),
    .flags_o      (flags_d),
    .res_o        (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q  <= '0;
      ip_q    <= '0;
      flags_q <= '0;
      vld_q   <= 1'b0;
      res_q   <= '0;
    end else begin
      if (acc) begin
        regs_q  <= regs_d;
        ip_q    <= ip_d;
        flags_q <= flags_d;
        res_q   <= res_d;
        vld_q   <= 1'b1;
      end else if (m_axis_tready_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = vld_q;
  assign m_axis_tdata_o  = {2'd0, res_q.read_value, res_q.mem_write_data,
                            res_q.mem_write_addr, res_q.mem_write_valid,
                            res_q.next_ip, res_q.instr_len, res_q.status};

  `X86ISE_ASSERT(a_bad_op_len, !(vld_q && res_q.status == ST_BAD_OP) || res_q.instr_len == 3'd1, "bad opcode must consume one byte")
  `X86ISE_ASSERT(a_push_xfer, !res_q.mem_write_valid || (res_q.instr_len == 3'd0 && res_q.status == ST_OK), "push only on taken call")
  `X86ISE_ASSERT_NEXT(a_ip_hold, !acc, ip_q == $past(ip_q), "eip moved without a word")
endmodule
